>>> design/smf_pkg.sv
// Shared types, constants and byte helpers for the substring match finder.
package smf_pkg;

  localparam int NEEDLE_BYTES = 16;
  localparam int NLEN_W       = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  localparam int DEF_MAX_NEEDLE  = 16;
  localparam int DEF_COLUMN_BITS = 16;
  localparam int DEF_LINE_BITS   = 20;

  localparam logic [7:0] UNDERSCORE = 8'h5F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CASE_SENS  = 3'd0,
    REG_WHOLE_WORD = 3'd1,
    REG_NEEDLE_LEN = 3'd2,
    REG_NEEDLE_LO  = 3'd3,
    REG_NEEDLE_HI  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                              case_sensitive;
    logic                              whole_word;
    logic [NLEN_W-1:0]                 needle_length;
    logic [NEEDLE_BYTES-1:0][7:0]      needle;
  } cfg_t;

  typedef struct packed {
    logic hit;
    logic left_word;
  } match_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
    logic [7:0] r;
    r = b;
    if (!cs && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == UNDERSCORE);
  endfunction

endpackage

>>> design/smf_cfg_regs.sv
// Configuration register file: case mode, whole-word mode, needle length and bytes.
module smf_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              we,
  input  logic [smf_pkg::CFG_IDX_W-1:0]     index,
  input  logic [smf_pkg::CFG_DATA_W-1:0]    data,
  output smf_pkg::cfg_t                     cfg
);
  import smf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        REG_CASE_SENS:  cfg_nxt.case_sensitive = data[0];
        REG_WHOLE_WORD: cfg_nxt.whole_word     = data[0];
        REG_NEEDLE_LEN: cfg_nxt.needle_length  = data[NLEN_W-1:0];
        REG_NEEDLE_LO:  cfg_nxt.needle[7:0]    = data;
        REG_NEEDLE_HI:  cfg_nxt.needle[15:8]   = data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/smf_matcher.sv
// Parallel window compare: needle against the newest bytes, plus left-neighbor word check.
module smf_matcher #(
  parameter int MAX_NEEDLE  = smf_pkg::DEF_MAX_NEEDLE,
  parameter int COLUMN_BITS = smf_pkg::DEF_COLUMN_BITS
) (
  input  smf_pkg::cfg_t                  cfg,
  input  logic [MAX_NEEDLE:0][7:0]       win,
  input  logic [COLUMN_BITS-1:0]         col,
  output smf_pkg::match_t                match
);
  import smf_pkg::*;

  localparam int CMP_W  = ((COLUMN_BITS > NLEN_W) ? COLUMN_BITS : NLEN_W) + 1;
  localparam int WIN_IW = $clog2(MAX_NEEDLE + 1);

  logic [NLEN_W-1:0]     len;
  logic [CMP_W-1:0]      col_x;
  logic [CMP_W-1:0]      len_x;
  logic                  len_ok;
  logic                  span_ok;
  logic [MAX_NEEDLE-1:0] byte_ok;
  logic [NLEN_W-1:0]     left_idx;

  assign len     = cfg.needle_length;
  assign col_x   = CMP_W'(col);
  assign len_x   = CMP_W'(len);
  assign len_ok  = (len != '0) && (len <= NLEN_W'(MAX_NEEDLE));
  assign span_ok = (col_x + CMP_W'(1)) >= len_x;

  // Needle byte j lines up with window byte len-1-j.
  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cmp
    logic [NLEN_W-1:0] k_full;
    logic [7:0]        sel;
    assign k_full     = len - NLEN_W'(1) - NLEN_W'(j);
    assign sel        = win[k_full[WIN_IW-1:0]];
    assign byte_ok[j] = (NLEN_W'(j) >= len) ||
                        (fold_byte(sel, cfg.case_sensitive) ==
                         fold_byte(cfg.needle[j], cfg.case_sensitive));
  end

  assign left_idx = len;

  assign match.hit       = len_ok && span_ok && (&byte_ok);
  assign match.left_word = (col_x >= len_x) && is_word(win[left_idx[WIN_IW-1:0]]);

endmodule

>>> design/smf_out_buf.sv
// Two-slot result register: holds up to two results of one item and drains them in order.
module smf_out_buf #(
  parameter int COLUMN_BITS = smf_pkg::DEF_COLUMN_BITS,
  parameter int LINE_BITS   = smf_pkg::DEF_LINE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [1:0]             n_in,
  input  logic [LINE_BITS-1:0]   r0_line,
  input  logic [COLUMN_BITS-1:0] r0_start,
  input  logic [COLUMN_BITS-1:0] r0_end,
  input  logic [LINE_BITS-1:0]   r1_line,
  input  logic [COLUMN_BITS-1:0] r1_start,
  input  logic [COLUMN_BITS-1:0] r1_end,
  output logic                   can_accept,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LINE_BITS-1:0]   out_line,
  output logic [COLUMN_BITS-1:0] out_start,
  output logic [COLUMN_BITS-1:0] out_end,
  output logic                   out_last
);
  import smf_pkg::*;

  logic [1:0]             cnt_r, cnt_nxt;
  logic [LINE_BITS-1:0]   s0_line_r, s1_line_r;
  logic [COLUMN_BITS-1:0] s0_start_r, s1_start_r;
  logic [COLUMN_BITS-1:0] s0_end_r, s1_end_r;
  logic                   s0_last_r;
  logic                   pop;

  assign pop        = out_valid && out_ready;
  assign can_accept = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_comb begin
    if (push) begin
      cnt_nxt = n_in;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s0_line_r  <= r0_line;
      s0_start_r <= r0_start;
      s0_end_r   <= r0_end;
      s0_last_r  <= (n_in == 2'd1);
      s1_line_r  <= r1_line;
      s1_start_r <= r1_start;
      s1_end_r   <= r1_end;
    end else if (pop) begin
      s0_line_r  <= s1_line_r;
      s0_start_r <= s1_start_r;
      s0_end_r   <= s1_end_r;
      s0_last_r  <= 1'b1;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_line  = s0_line_r;
  assign out_start = s0_start_r;
  assign out_end   = s0_end_r;
  assign out_last  = s0_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result count out of range");
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push && n_in == 2'd2) |=> (cnt_r == 2'd2 && !s0_last_r))
    else $error("first of two results flagged last");
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> s0_last_r)
    else $error("lone result not flagged last");

endmodule

>>> design/substring_match_finder.sv
// Top level of the streaming substring match finder.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one text item per cycle while in_ready
//   is high: a byte, a line-end flag and an empty-line flag. Result channel
//   (out_valid/out_ready) gives matches as line, start column, end column and
//   a flag on the last result produced by its item. The user must write
//   configuration (cfg_we, cfg_index, cfg_data) only while the block is idle;
//   the block itself does not enforce this. An accepted item is held in the
//   input register, which feeds the compare, which loads the result register.
//   Throughput: one item per cycle while items produce at most one result and
//   the receiver is ready; an item producing two results holds the result
//   register until its first result drains through the single output slot.
//   Reset clears configuration, line and column counters, the byte history
//   and any pending whole-word match; no result is held after reset.
//   When the receiver stalls, the result register holds its results and the
//   input register holds one more item before in_ready drops.
module substring_match_finder #(
  parameter int MAX_NEEDLE  = smf_pkg::DEF_MAX_NEEDLE,
  parameter int COLUMN_BITS = smf_pkg::DEF_COLUMN_BITS,
  parameter int LINE_BITS   = smf_pkg::DEF_LINE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [smf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_line_end,
  input  logic                            in_empty_line,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [LINE_BITS-1:0]            out_match_line,
  output logic [COLUMN_BITS-1:0]          out_match_start,
  output logic [COLUMN_BITS-1:0]          out_match_end,
  output logic                            out_last_of_run
);
  import smf_pkg::*;

  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam int CMP_W = ((COLUMN_BITS > NLEN_W) ? COLUMN_BITS : NLEN_W) + 1;

  cfg_t   cfg;
  match_t match;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_line_end_r;
  logic       s1_empty_r;
  logic       in_fire;
  logic       adv;
  logic       buf_can_accept;

  // Stream state
  logic [MAX_NEEDLE-1:0][7:0] hist_r, hist_nxt;
  logic [COLUMN_BITS-1:0]     col_r, col_nxt;
  logic [LINE_BITS-1:0]       line_r, line_nxt;
  logic                       pend_r, pend_nxt;
  logic [COLUMN_BITS-1:0]     pend_start_r, pend_start_nxt;

  logic [MAX_NEEDLE:0][7:0]   win;
  logic [COLUMN_BITS-1:0]     col_inc;
  logic [LINE_BITS-1:0]       line_inc;
  logic [CMP_W-1:0]           start_x;
  logic [COLUMN_BITS-1:0]     m_start;
  logic [COLUMN_BITS-1:0]     m_end;
  logic                       pend_emit;
  logic                       new_emit;
  logic                       new_pend;
  logic [1:0]                 n_res;
  logic [COLUMN_BITS-1:0]     r0_start, r0_end;

  smf_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Handshake: advance the held item whenever the result register has room.
  assign adv      = s1_valid_r && buf_can_accept;
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r     <= in_text_byte;
      s1_line_end_r <= in_line_end;
      s1_empty_r    <= in_empty_line;
    end
  end

  // Window after shifting in the current byte: index 0 is the newest.
  assign win = {hist_r, s1_byte_r};

  smf_matcher #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_match (
    .cfg   (cfg),
    .win   (win),
    .col   (col_r),
    .match (match)
  );

  assign col_inc  = (col_r == COL_MAX) ? COL_MAX : col_r + 1'b1;
  assign line_inc = (line_r == LINE_MAX) ? LINE_MAX : line_r + 1'b1;
  assign start_x  = CMP_W'(col_r) + CMP_W'(1) - CMP_W'(cfg.needle_length);
  assign m_start  = start_x[COLUMN_BITS-1:0];
  assign m_end    = col_inc;

  // A pending whole-word match resolves on a non-word byte or a closed line.
  assign pend_emit = pend_r && (s1_empty_r || !is_word(s1_byte_r));

  // New match: report now unless whole-word mode needs the right neighbor or rejects a word left neighbor.
  always_comb begin
    new_emit = 1'b0;
    new_pend = 1'b0;
    if (!s1_empty_r && match.hit) begin
      if (!cfg.whole_word) begin
        new_emit = 1'b1;
      end else if (!match.left_word) begin
        new_emit = s1_line_end_r;
        new_pend = !s1_line_end_r;
      end
    end
  end

  assign n_res    = {1'b0, pend_emit} + {1'b0, new_emit};
  assign r0_start = pend_emit ? pend_start_r : m_start;
  assign r0_end   = pend_emit ? col_r : m_end;

  always_comb begin
    hist_nxt       = hist_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    pend_nxt       = pend_r;
    pend_start_nxt = pend_start_r;
    if (adv) begin
      if (s1_empty_r) begin
        pend_nxt = 1'b0;
        line_nxt = line_inc;
        col_nxt  = '0;
      end else begin
        hist_nxt       = win[MAX_NEEDLE-1:0];
        pend_nxt       = new_pend;
        pend_start_nxt = m_start;
        if (s1_line_end_r) begin
          line_nxt = line_inc;
          col_nxt  = '0;
        end else begin
          col_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      col_r        <= '0;
      line_r       <= '0;
      pend_r       <= 1'b0;
      pend_start_r <= '0;
    end else begin
      hist_r       <= hist_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      pend_r       <= pend_nxt;
      pend_start_r <= pend_start_nxt;
    end
  end

  smf_out_buf #(
    .COLUMN_BITS (COLUMN_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (adv),
    .n_in       (n_res),
    .r0_line    (line_r),
    .r0_start   (r0_start),
    .r0_end     (r0_end),
    .r1_line    (line_r),
    .r1_start   (m_start),
    .r1_end     (m_end),
    .can_accept (buf_can_accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_line   (out_match_line),
    .out_start  (out_match_start),
    .out_end    (out_match_end),
    .out_last   (out_last_of_run)
  );

  a_pend_cleared_at_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (s1_empty_r || s1_line_end_r)) |=> (!pend_r && col_r == '0))
    else $error("line close left pending match or column");
  a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (line_r >= $past(line_r)))
    else $error("line counter went backwards");
  a_pend_needs_ww: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg.whole_word && !pend_r) |=> !pend_r)
    else $error("pending match without whole-word mode");

endmodule
